// ===== sv/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types and constants for the depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

    // Input field widths
    localparam int COORD_W = 12;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;

    // Configuration widths
    localparam int INV_FOCAL_W = 24;
    localparam int CENTER_W    = 16;
    localparam int POSE_W      = 64;
    localparam int ROT_W       = 16;
    localparam int TRANS_W     = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;

    // Valid depth window, Q4.12 (0.01 m to 4 m inclusive)
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 16'd41;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd16384;

    // Datapath widths
    localparam int Z_W        = 15;   // depth of a kept pixel fits 15 bits
    localparam int DELTA_W    = 17;   // column*16 - center, Q.4
    localparam int PROD_W     = 32;   // delta * depth
    localparam int SCALED_W   = 56;   // delta * depth * inv_focal
    localparam int CAM_SHIFT  = 28;
    localparam int CAM_W      = 28;   // camera x/y, Q.12
    localparam int XY_TERM_W  = 44;   // rotation * camera x/y
    localparam int Z_TERM_W   = 30;   // rotation * depth
    localparam int TRANS_SHIFT = 18;
    localparam int ACC_W      = 45;   // world coordinate, Q.26
    localparam int WORLD_SHIFT = 14;
    localparam int RND_W      = ACC_W - WORLD_SHIFT;
    localparam int OUT_W      = 20;

    localparam logic signed [SCALED_W-1:0] CAM_HALF   = SCALED_W'(1) <<< (CAM_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]    WORLD_HALF = ACC_W'(1) <<< (WORLD_SHIFT - 1);
    localparam logic signed [RND_W-1:0]    OUT_MAX    = RND_W'(524287);
    localparam logic signed [RND_W-1:0]    OUT_MIN    = -RND_W'(524288);

    // Register map (index = byte address / 8)
    typedef enum logic [2:0] {
        CFG_INV_FOCAL_X = 3'd0,
        CFG_INV_FOCAL_Y = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_POSE_ROW0   = 3'd4,
        CFG_POSE_ROW1   = 3'd5,
        CFG_POSE_ROW2   = 3'd6
    } cfg_idx_t;

    // Register reset values (identity pose)
    localparam logic [INV_FOCAL_W-1:0] INV_FOCAL_RST = 24'd31957;
    localparam logic [CENTER_W-1:0]    CENTER_X_RST  = 16'd5112;
    localparam logic [CENTER_W-1:0]    CENTER_Y_RST  = 16'd3832;
    localparam logic [POSE_W-1:0]      POSE_ROW0_RST = 64'h0000_0000_0000_4000;
    localparam logic [POSE_W-1:0]      POSE_ROW1_RST = 64'h0000_0000_4000_0000;
    localparam logic [POSE_W-1:0]      POSE_ROW2_RST = 64'h0000_4000_0000_0000;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgb_t;

    // Front stage result: pixel offsets from the principal point
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [Z_W-1:0]            z;
        rgb_t                      color;
    } front_t;

    // Camera-frame point
    typedef struct packed {
        logic signed [CAM_W-1:0] x;
        logic signed [CAM_W-1:0] y;
        logic [Z_W-1:0]          z;
        rgb_t                    color;
    } cam_t;

endpackage

// ===== sv/depth_pixel_to_world_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Depth pixel back-projection to a colored world point, APB configured.
// ----------------------------------------------------------------------------
// One pixel transaction is taken per clock while s_tready is high. The datapath
// is seven register stages (filter, two multiplies for back-projection,
// rounding, rotation products, sum, round and clamp), the last of them the
// output register. Pixels off the stride grid or outside the depth window are
// dropped in the first stage and leave a bubble that later stalls squeeze out.
// Each stage holds while the one after it is full and stalled, so s_tready
// only drops when the output register holds a result that is not taken and
// every stage behind it is full. Configuration registers are live: write them
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point #(
    parameter int STRIDE = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // column, pixel_row, depth, red_in, green_in, blue_in
    // World point stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [87:0]                         m_tdata,  // world_x, world_y, world_z, red_out, green_out, blue_out, zero pad
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpw_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dpw_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [dpw_pkg::INV_FOCAL_W-1:0]   inv_focal_x_reg, inv_focal_y_reg;
    logic [dpw_pkg::CENTER_W-1:0]      center_x_reg, center_y_reg;
    logic [2:0][dpw_pkg::POSE_W-1:0]   pose_reg;
    dpw_pkg::cfg_idx_t                 cfg_idx;
    logic                              cfg_wr;

    dpw_pkg::rgb_t                     in_color;
    logic                              front_valid, front_ready;
    dpw_pkg::front_t                   front_data;
    logic                              cam_valid, cam_ready;
    dpw_pkg::cam_t                     cam_data;
    logic [2:0][dpw_pkg::OUT_W-1:0]    world;
    dpw_pkg::rgb_t                     out_color;

    // Register file
    assign pready  = 1'b1;
    assign cfg_idx = dpw_pkg::cfg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= dpw_pkg::INV_FOCAL_RST;
            inv_focal_y_reg <= dpw_pkg::INV_FOCAL_RST;
            center_x_reg    <= dpw_pkg::CENTER_X_RST;
            center_y_reg    <= dpw_pkg::CENTER_Y_RST;
            pose_reg[0]     <= dpw_pkg::POSE_ROW0_RST;
            pose_reg[1]     <= dpw_pkg::POSE_ROW1_RST;
            pose_reg[2]     <= dpw_pkg::POSE_ROW2_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                dpw_pkg::CFG_INV_FOCAL_X: inv_focal_x_reg <= pwdata[dpw_pkg::INV_FOCAL_W-1:0];
                dpw_pkg::CFG_INV_FOCAL_Y: inv_focal_y_reg <= pwdata[dpw_pkg::INV_FOCAL_W-1:0];
                dpw_pkg::CFG_CENTER_X:    center_x_reg    <= pwdata[dpw_pkg::CENTER_W-1:0];
                dpw_pkg::CFG_CENTER_Y:    center_y_reg    <= pwdata[dpw_pkg::CENTER_W-1:0];
                dpw_pkg::CFG_POSE_ROW0:   pose_reg[0]     <= pwdata;
                dpw_pkg::CFG_POSE_ROW1:   pose_reg[1]     <= pwdata;
                dpw_pkg::CFG_POSE_ROW2:   pose_reg[2]     <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_idx)
            dpw_pkg::CFG_INV_FOCAL_X: prdata = dpw_pkg::CFG_DATA_W'(inv_focal_x_reg);
            dpw_pkg::CFG_INV_FOCAL_Y: prdata = dpw_pkg::CFG_DATA_W'(inv_focal_y_reg);
            dpw_pkg::CFG_CENTER_X:    prdata = dpw_pkg::CFG_DATA_W'(center_x_reg);
            dpw_pkg::CFG_CENTER_Y:    prdata = dpw_pkg::CFG_DATA_W'(center_y_reg);
            dpw_pkg::CFG_POSE_ROW0:   prdata = pose_reg[0];
            dpw_pkg::CFG_POSE_ROW1:   prdata = pose_reg[1];
            dpw_pkg::CFG_POSE_ROW2:   prdata = pose_reg[2];
            default:                  prdata = '0;
        endcase
    end

    // Input unpacking
    assign in_color.red   = s_tdata[47:40];
    assign in_color.green = s_tdata[55:48];
    assign in_color.blue  = s_tdata[63:56];

    dpw_front #(
        .STRIDE (STRIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .column    (s_tdata[11:0]),
        .pixel_row (s_tdata[23:12]),
        .depth     (s_tdata[39:24]),
        .color     (in_color),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    dpw_backproj u_backproj (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (front_valid),
        .in_ready    (front_ready),
        .in_data     (front_data),
        .inv_focal_x (inv_focal_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .out_valid   (cam_valid),
        .out_ready   (cam_ready),
        .out_data    (cam_data)
    );

    dpw_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cam_valid),
        .in_ready  (cam_ready),
        .in_data   (cam_data),
        .pose      (pose_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .world     (world),
        .color     (out_color)
    );

    // Output packing
    assign m_tdata = {4'b0000, out_color.blue, out_color.green, out_color.red,
                      world[2], world[1], world[0]};

endmodule

// ===== sv/dpw_front.sv =====
// ----------------------------------------------------------------------------
// dpw_front
// Stride and depth filter, offsets from the principal point. One stage.
// ----------------------------------------------------------------------------
module dpw_front #(
    parameter int STRIDE = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dpw_pkg::COORD_W-1:0]         column,
    input  logic [dpw_pkg::COORD_W-1:0]         pixel_row,
    input  logic [dpw_pkg::DEPTH_W-1:0]         depth,
    input  dpw_pkg::rgb_t                       color,
    input  logic [dpw_pkg::CENTER_W-1:0]        center_x,
    input  logic [dpw_pkg::CENTER_W-1:0]        center_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dpw_pkg::front_t                     out_data
);

    // Stride test by reciprocal multiply: q = (v * RECIP) >> RECIP_SHIFT is exact
    // for 12-bit v and stride up to 8.
    localparam int    RECIP_SHIFT = 24;
    localparam int    RECIP_W     = RECIP_SHIFT + 1;
    localparam int    STRIDE_W    = 4;
    localparam int    MPROD_W     = dpw_pkg::COORD_W + RECIP_W;
    localparam int    BACK_W      = dpw_pkg::COORD_W + STRIDE_W;
    localparam longint RECIP_L    = ((longint'(1) << RECIP_SHIFT) + STRIDE - 1) / STRIDE;
    localparam logic [RECIP_W-1:0]  RECIP    = RECIP_L[RECIP_W-1:0];
    localparam logic [STRIDE_W-1:0] STRIDE_V = STRIDE[STRIDE_W-1:0];

    function automatic logic on_stride(input logic [dpw_pkg::COORD_W-1:0] v);
        logic [MPROD_W-1:0]          prod;
        logic [dpw_pkg::COORD_W-1:0] quot;
        logic [BACK_W-1:0]           back;
        prod = MPROD_W'(v) * MPROD_W'(RECIP);
        quot = prod[RECIP_SHIFT +: dpw_pkg::COORD_W];
        back = BACK_W'(quot) * BACK_W'(STRIDE_V);
        return back == BACK_W'(v);
    endfunction

    logic            keep;
    logic            en;
    logic            vld_reg;
    dpw_pkg::front_t data_next;
    dpw_pkg::front_t data_reg;

    // Filter and offsets
    always_comb
    begin
        keep = on_stride(column) && on_stride(pixel_row) &&
               (depth >= dpw_pkg::DEPTH_MIN) && (depth <= dpw_pkg::DEPTH_MAX);
        data_next.dx = $signed({1'b0, column, 4'b0000}) - $signed({1'b0, center_x});
        data_next.dy = $signed({1'b0, pixel_row, 4'b0000}) - $signed({1'b0, center_y});
        data_next.z  = depth[dpw_pkg::Z_W-1:0];
        data_next.color = color;
    end

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/dpw_backproj.sv =====
// ----------------------------------------------------------------------------
// dpw_backproj
// Pinhole back-projection: offset * depth, * reciprocal focal, round. 3 stages.
// ----------------------------------------------------------------------------
module dpw_backproj (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dpw_pkg::front_t                    in_data,
    input  logic [dpw_pkg::INV_FOCAL_W-1:0]    inv_focal_x,
    input  logic [dpw_pkg::INV_FOCAL_W-1:0]    inv_focal_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output dpw_pkg::cam_t                      out_data
);

    localparam int FULL1_W = dpw_pkg::DELTA_W + dpw_pkg::Z_W + 1;
    localparam int FULL2_W = dpw_pkg::PROD_W + dpw_pkg::INV_FOCAL_W + 1;

    typedef struct packed {
        logic signed [dpw_pkg::PROD_W-1:0] px;
        logic signed [dpw_pkg::PROD_W-1:0] py;
        logic [dpw_pkg::Z_W-1:0]           z;
        dpw_pkg::rgb_t                     color;
    } prod_t;

    typedef struct packed {
        logic signed [dpw_pkg::SCALED_W-1:0] sx;
        logic signed [dpw_pkg::SCALED_W-1:0] sy;
        logic [dpw_pkg::Z_W-1:0]             z;
        dpw_pkg::rgb_t                       color;
    } scaled_t;

    logic          vld_b_reg, vld_c_reg, vld_d_reg;
    logic          en_b, en_c, en_d;
    prod_t         prod_next, prod_reg;
    scaled_t       scaled_next, scaled_reg;
    dpw_pkg::cam_t cam_next, cam_reg;

    logic signed [FULL1_W-1:0] full1_x, full1_y;
    logic signed [FULL2_W-1:0] full2_x, full2_y;
    logic signed [dpw_pkg::SCALED_W-1:0] rnd_x, rnd_y;

    // Ready chain: a stage moves when it is empty or the next one moves
    assign en_d     = !vld_d_reg || out_ready;
    assign en_c     = !vld_c_reg || en_d;
    assign en_b     = !vld_b_reg || en_c;
    assign in_ready = en_b;

    // Stage B: offset times depth
    always_comb
    begin
        full1_x = in_data.dx * $signed({1'b0, in_data.z});
        full1_y = in_data.dy * $signed({1'b0, in_data.z});
        prod_next.px    = full1_x[dpw_pkg::PROD_W-1:0];
        prod_next.py    = full1_y[dpw_pkg::PROD_W-1:0];
        prod_next.z     = in_data.z;
        prod_next.color = in_data.color;
    end

    // Stage C: times reciprocal focal length
    always_comb
    begin
        full2_x = prod_reg.px * $signed({1'b0, inv_focal_x});
        full2_y = prod_reg.py * $signed({1'b0, inv_focal_y});
        scaled_next.sx    = full2_x[dpw_pkg::SCALED_W-1:0];
        scaled_next.sy    = full2_y[dpw_pkg::SCALED_W-1:0];
        scaled_next.z     = prod_reg.z;
        scaled_next.color = prod_reg.color;
    end

    // Stage D: round to Q.12, ties toward plus infinity
    always_comb
    begin
        rnd_x = scaled_reg.sx + dpw_pkg::CAM_HALF;
        rnd_y = scaled_reg.sy + dpw_pkg::CAM_HALF;
        cam_next.x     = rnd_x[dpw_pkg::CAM_SHIFT +: dpw_pkg::CAM_W];
        cam_next.y     = rnd_y[dpw_pkg::CAM_SHIFT +: dpw_pkg::CAM_W];
        cam_next.z     = scaled_reg.z;
        cam_next.color = scaled_reg.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            if (en_b)
            begin
                vld_b_reg <= in_valid;
            end
            if (en_c)
            begin
                vld_c_reg <= vld_b_reg;
            end
            if (en_d)
            begin
                vld_d_reg <= vld_c_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            prod_reg <= prod_next;
        end
        if (en_c)
        begin
            scaled_reg <= scaled_next;
        end
        if (en_d)
        begin
            cam_reg <= cam_next;
        end
    end

    assign out_valid = vld_d_reg;
    assign out_data  = cam_reg;

endmodule

// ===== sv/dpw_transform.sv =====
// ----------------------------------------------------------------------------
// dpw_transform
// Rigid transform camera to world, rounding and saturation. 3 stages, the
// last one is the output register.
// ----------------------------------------------------------------------------
module dpw_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  dpw_pkg::cam_t                        in_data,
    input  logic [2:0][dpw_pkg::POSE_W-1:0]      pose,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0][dpw_pkg::OUT_W-1:0]       world,
    output dpw_pkg::rgb_t                        color
);

    localparam int FULLZ_W = dpw_pkg::ROT_W + dpw_pkg::Z_W + 1;

    logic vld_e_reg, vld_f_reg, vld_g_reg;
    logic en_e, en_f, en_g;

    logic signed [2:0][dpw_pkg::XY_TERM_W-1:0] tx_next, tx_reg;
    logic signed [2:0][dpw_pkg::XY_TERM_W-1:0] ty_next, ty_reg;
    logic signed [2:0][dpw_pkg::Z_TERM_W-1:0]  tz_next, tz_reg;
    logic signed [2:0][dpw_pkg::ACC_W-1:0]     acc_next, acc_reg;
    logic [2:0][dpw_pkg::OUT_W-1:0]            world_next, world_reg;
    dpw_pkg::rgb_t                             color_e_reg, color_f_reg, color_g_reg;

    logic signed [2:0][FULLZ_W-1:0]            fullz;
    logic signed [2:0][dpw_pkg::ACC_W-1:0]     rnd;
    logic signed [2:0][dpw_pkg::RND_W-1:0]     shifted;

    assign en_g     = !vld_g_reg || out_ready;
    assign en_f     = !vld_f_reg || en_g;
    assign en_e     = !vld_e_reg || en_f;
    assign in_ready = en_e;

    // Stage E: nine rotation products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tx_next[i] = $signed(pose[i][0 +: dpw_pkg::ROT_W]) * in_data.x;
            ty_next[i] = $signed(pose[i][16 +: dpw_pkg::ROT_W]) * in_data.y;
            fullz[i]   = $signed(pose[i][32 +: dpw_pkg::ROT_W]) * $signed({1'b0, in_data.z});
            tz_next[i] = fullz[i][dpw_pkg::Z_TERM_W-1:0];
        end
    end

    // Stage F: sum with translation, Q.26 (elements of a packed array read unsigned)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = dpw_pkg::ACC_W'($signed(tx_reg[i])) +
                          dpw_pkg::ACC_W'($signed(ty_reg[i])) +
                          dpw_pkg::ACC_W'($signed(tz_reg[i])) +
                          (dpw_pkg::ACC_W'($signed(pose[i][48 +: dpw_pkg::TRANS_W]))
                           <<< dpw_pkg::TRANS_SHIFT);
        end
    end

    // Stage G: round to Q.12 and clamp to Q8.12
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]     = acc_reg[i] + dpw_pkg::WORLD_HALF;
            shifted[i] = rnd[i][dpw_pkg::WORLD_SHIFT +: dpw_pkg::RND_W];
            if ($signed(shifted[i]) > dpw_pkg::OUT_MAX)
            begin
                world_next[i] = dpw_pkg::OUT_MAX[dpw_pkg::OUT_W-1:0];
            end
            else if ($signed(shifted[i]) < dpw_pkg::OUT_MIN)
            begin
                world_next[i] = dpw_pkg::OUT_MIN[dpw_pkg::OUT_W-1:0];
            end
            else
            begin
                world_next[i] = shifted[i][dpw_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end
        else
        begin
            if (en_e)
            begin
                vld_e_reg <= in_valid;
            end
            if (en_f)
            begin
                vld_f_reg <= vld_e_reg;
            end
            if (en_g)
            begin
                vld_g_reg <= vld_f_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            tz_reg      <= tz_next;
            color_e_reg <= in_data.color;
        end
        if (en_f)
        begin
            acc_reg     <= acc_next;
            color_f_reg <= color_e_reg;
        end
        if (en_g)
        begin
            world_reg   <= world_next;
            color_g_reg <= color_f_reg;
        end
    end

    assign out_valid = vld_g_reg;
    assign world     = world_reg;
    assign color     = color_g_reg;

endmodule

// ===== sv/dpw_checker.sv =====
// ----------------------------------------------------------------------------
// dpw_checker
// Port-level checks for depth_pixel_to_world_point, bound to the top level.
// ----------------------------------------------------------------------------
module dpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    logic seen_reg;
    logic seen_next;

    // Any pixel transaction since reset
    assign seen_next = seen_reg || (s_tvalid && s_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // A held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A held result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // Input only backs up behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output backpressure");

    // No result without an earlier pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> seen_reg)
        else $error("result offered before any pixel was accepted");

endmodule

bind depth_pixel_to_world_point dpw_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
